/* hdl/sha_pkg.sv */
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned ChainWords = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic add;
  } sha_rnd_ctrl_t;

  typedef struct packed {
    logic        wr;
    logic        pad;
    logic        pad_len;
    logic        len_blk;
    logic        shift;
    logic [5:0]  addr;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } sha_sch_ctrl_t;

  localparam word_t InitH [ChainWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

/* hdl/sha_stream_if.sv */
interface sha_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/sha256_stream_hasher_core.sv */
// Channel  Dir  Payload                                    Transaction
// in_i     in   data_byte, byte_present, end_of_message    one byte slot, optional end mark
// out_o    out  digest_word, word_index, last_word         one digest word, eight per message
//
// A byte that does not complete a block is stored; without an end mark in_i stays ready.
// A byte that completes a block starts a compression: 64 rounds in the single round unit, 1 add.
// End of message compresses the padded block, and a length block when the length spills over,
// then sends 8 digest words at one per cycle while out_o is ready.
// in_i is not ready during a block compression, nor from the end mark until the last
// digest word goes out.
// Reset loads the initial hash and clears the fill and length counters.
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha_stream_if.sink   in_i,
  sha_stream_if.source out_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_LEN  = 6'b000100,
    S_COMP = 6'b001000,
    S_ADD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  state_e        ret_q, ret_d;
  logic [5:0]    fill_q, fill_d;
  logic [60:0]   len_q, len_d;
  logic [5:0]    rnd_q, rnd_d;
  logic [2:0]    widx_q, widx_d;
  sha_sch_ctrl_t sch;
  sha_rnd_ctrl_t rnd;
  word_t         wt;
  word_t         chain [ChainWords];
  logic          in_fire;
  logic          out_fire;

  sha_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sch),
    .wt_o   (wt)
  );

  sha_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rnd),
    .rnd_i   (rnd_q),
    .wt_i    (wt),
    .chain_o (chain)
  );

  assign in_i.ready                = (state_q == S_IDLE);
  assign out_o.valid               = (state_q == S_OUT);
  assign out_o.payload.digest_word = chain[widx_q];
  assign out_o.payload.word_index  = widx_q;
  assign out_o.payload.last_word   = (widx_q == 3'(ChainWords - 1));

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    len_d       = len_q;
    rnd_d       = rnd_q;
    widx_d      = widx_q;
    sch         = '0;
    sch.bit_len = {len_q, 3'b000};
    rnd         = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.payload.byte_present) begin
            sch.wr   = 1'b1;
            sch.addr = fill_q;
            sch.data = in_i.payload.data_byte;
            fill_d   = fill_q + 6'd1;
            len_d    = len_q + 61'd1;
            if (fill_q == 6'(BlockBytes - 1)) begin
              rnd.load = 1'b1;
              state_d  = S_COMP;
              ret_d    = in_i.payload.end_of_message ? S_PAD : S_IDLE;
            end else if (in_i.payload.end_of_message) begin
              state_d = S_PAD;
            end
          end else if (in_i.payload.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        sch.pad  = 1'b1;
        sch.addr = fill_q;
        rnd.load = 1'b1;
        fill_d   = '0;
        state_d  = S_COMP;
        if (fill_q < 6'(LenPos)) begin
          sch.pad_len = 1'b1;
          ret_d       = S_OUT;
        end else begin
          ret_d = S_LEN;
        end
      end
      S_LEN: begin
        sch.len_blk = 1'b1;
        rnd.load    = 1'b1;
        ret_d       = S_OUT;
        state_d     = S_COMP;
      end
      S_COMP: begin
        rnd.step  = 1'b1;
        sch.shift = 1'b1;
        if (rnd_q == 6'(NumRounds - 1)) begin
          rnd_d   = '0;
          state_d = S_ADD;
        end else begin
          rnd_d = rnd_q + 6'd1;
        end
      end
      S_ADD: begin
        rnd.add = 1'b1;
        state_d = ret_q;
      end
      S_OUT: begin
        if (out_fire) begin
          if (widx_q == 3'(ChainWords - 1)) begin
            widx_d   = '0;
            rnd.init = 1'b1;
            len_d    = '0;
            state_d  = S_IDLE;
          end else begin
            widx_d = widx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      fill_q  <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input taken while digest pending");

  a_clear_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.payload.last_word) |=> (len_q == '0 && fill_q == '0 && in_i.ready))
    else $error("state not cleared after digest");

  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_o.payload.last_word) |=>
      (out_o.valid && out_o.payload.word_index == $past(out_o.payload.word_index) + 3'd1))
    else $error("digest word order broken");

  a_round_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP && rnd_q != 6'(NumRounds - 1)) |=>
      (state_q == S_COMP && rnd_q == $past(rnd_q) + 6'd1))
    else $error("round counter skipped");
`endif

endmodule

/* hdl/sha_sched.sv */
module sha_sched
  import sha_pkg::*;
(
  input  logic          clk_i,
  input  sha_sch_ctrl_t ctrl_i,
  output word_t         wt_o
);

  word_t words_q [BlockWords];
  word_t words_d [BlockWords];

  always_comb begin
    words_d = words_q;
    if (ctrl_i.wr) begin
      words_d[ctrl_i.addr[5:2]][{~ctrl_i.addr[1:0], 3'b000} +: 8] = ctrl_i.data;
    end else if (ctrl_i.pad) begin
      for (int b = 0; b < BlockBytes; b++) begin
        if (6'(b) == ctrl_i.addr) begin
          words_d[b / 4][(3 - (b % 4)) * 8 +: 8] = PadByte;
        end else if (6'(b) > ctrl_i.addr) begin
          words_d[b / 4][(3 - (b % 4)) * 8 +: 8] = 8'h00;
        end
      end
      if (ctrl_i.pad_len) begin
        words_d[BlockWords - 2] = ctrl_i.bit_len[63:32];
        words_d[BlockWords - 1] = ctrl_i.bit_len[31:0];
      end
    end else if (ctrl_i.len_blk) begin
      for (int i = 0; i < BlockWords - 2; i++) begin
        words_d[i] = '0;
      end
      words_d[BlockWords - 2] = ctrl_i.bit_len[63:32];
      words_d[BlockWords - 1] = ctrl_i.bit_len[31:0];
    end else if (ctrl_i.shift) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        words_d[i] = words_q[i + 1];
      end
      words_d[BlockWords - 1] = small_sig1(words_q[14]) + words_q[9]
                                + small_sig0(words_q[1]) + words_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

  assign wt_o = words_q[0];

endmodule

/* hdl/sha_round.sv */
module sha_round
  import sha_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sha_rnd_ctrl_t ctrl_i,
  input  logic [5:0]    rnd_i,
  input  word_t         wt_i,
  output word_t         chain_o [ChainWords]
);

  word_t chain_q [ChainWords];
  word_t chain_d [ChainWords];
  word_t work_q  [ChainWords];
  word_t work_d  [ChainWords];
  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  always_comb begin
    ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1  = work_q[7] + big_sig1(work_q[4]) + ch + RoundK[rnd_i] + wt_i;
    t2  = big_sig0(work_q[0]) + maj;
  end

  always_comb begin
    work_d = work_q;
    if (ctrl_i.load) begin
      work_d = chain_q;
    end else if (ctrl_i.step) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (ctrl_i.init) begin
      chain_d = InitH;
    end else if (ctrl_i.add) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitH;
    end else begin
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign chain_o = chain_q;

endmodule
